// ----- rtl/fdmd_pkg.sv -----
// package for the frame difference motion detector
// types, sizes and register indexes shared by every rtl file; depends on nothing
package fdmd_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);
    localparam int COUNT_W     = 19;
    localparam int DIM_W       = 10;
    localparam int TOL_W       = 8;
    localparam int SENS_W      = 12;
    localparam int CHAN_W      = 8;
    localparam int CFG_DATA_W  = 12;
    localparam int PROD_W      = COUNT_W + SENS_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // queue depth, a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_TOLERANCE    = 2'd0,
        CFG_SENSITIVITY  = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic               changed;
        logic               frame_end;
        logic               motion;
        logic [COUNT_W-1:0] changed_total;
    } t_result;

    typedef struct packed {
        t_pixel             pixel;
        logic [ADDR_W-1:0]  addr;
        logic [TOTAL_W-1:0] total;
        logic               last;
        logic               primed;
    } t_job;

    typedef struct packed {
        logic [TOL_W-1:0]  tolerance;
        logic [SENS_W-1:0] sensitivity;
    } t_cfg_ctl;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic near(input logic [CHAN_W-1:0] a,
                                  input logic [CHAN_W-1:0] b,
                                  input logic [TOL_W-1:0] tol);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

endpackage

// ----- rtl/frame_difference_motion_detector_unit.sv -----
// frame difference motion detector, top level
// ties front part, job queue and back part together; depends on fdmd_pkg
//
// usage:
//   pixels enter in raster order on i_valid/o_stall as a t_pixel beat; one
//   t_result beat leaves on o_valid/i_stall for every pixel, in order
//   registers are written over i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_data, by the user only while no pixel is in flight (unenforced);
//   o_cfg_ready is always high; a beat moves when valid is high, stall low
// timing:
//   one pixel per cycle is sustained while i_stall is low; the pace is set
//   by the pixel store, which does one read and one write of a stored pixel
//   each cycle, with the pixel just written forwarded to the next one at the
//   same address
// reset:
//   position, count and primed flag clear and registers take their defaults;
//   the store is not cleared, the first frame after reset only fills it
// stall:
//   the output beat holds; the compare stage and the two-entry queue fill,
//   then o_stall rises until the receiver takes the output beat
module frame_difference_motion_detector_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  fdmd_pkg::t_pixel                i_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output fdmd_pkg::t_result               o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [fdmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_not_empty;
    fdmd_pkg::t_job      front_job;
    fdmd_pkg::t_job      q_head;
    fdmd_pkg::t_cfg_ctl  cfg_ctl;

    fdmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .i_q_full    (q_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (q_push),
        .o_job       (front_job),
        .o_cfg_ctl   (cfg_ctl)
    );

    fdmd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_job       (front_job),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_not_empty (q_not_empty),
        .o_full      (q_full)
    );

    fdmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_not_empty (q_not_empty),
        .o_pop       (q_pop),
        .i_cfg_ctl   (cfg_ctl),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_stall     (i_stall)
    );

    assign o_stall     = q_full;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/fdmd_front.sv -----
// front part: configuration registers, pixel position and frame-end marking
// depends on fdmd_pkg
module fdmd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  fdmd_pkg::t_pixel               i_pixel,
    input  logic                           i_q_full,
    input  logic                           i_cfg_valid,
    input  logic [1:0]                     i_cfg_index,
    input  logic [fdmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_push,
    output fdmd_pkg::t_job                 o_job,
    output fdmd_pkg::t_cfg_ctl             o_cfg_ctl
);

    logic [fdmd_pkg::TOL_W-1:0]   r_tolerance;
    logic [fdmd_pkg::SENS_W-1:0]  r_sensitivity;
    logic [fdmd_pkg::DIM_W-1:0]   r_frame_width;
    logic [fdmd_pkg::DIM_W-1:0]   r_frame_height;
    logic [fdmd_pkg::ADDR_W-1:0]  r_pos;
    logic [fdmd_pkg::ADDR_W-1:0]  n_pos;
    logic                         r_primed;
    logic                         n_primed;

    logic [fdmd_pkg::DIM_W-1:0]   w_eff;
    logic [fdmd_pkg::DIM_W-1:0]   h_eff;
    logic [fdmd_pkg::TOTAL_W-1:0] total;
    logic [fdmd_pkg::TOTAL_W-1:0] pos_next;
    logic                         last;
    logic                         accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance    <= fdmd_pkg::TOL_W'(70);
            r_sensitivity  <= fdmd_pkg::SENS_W'(100);
            r_frame_width  <= fdmd_pkg::DIM_W'(320);
            r_frame_height <= fdmd_pkg::DIM_W'(240);
        end else if (i_cfg_valid) begin
            case (fdmd_pkg::t_cfg_idx'(i_cfg_index))
                fdmd_pkg::CFG_TOLERANCE:    r_tolerance    <= i_cfg_data[fdmd_pkg::TOL_W-1:0];
                fdmd_pkg::CFG_SENSITIVITY:  r_sensitivity  <= i_cfg_data[fdmd_pkg::SENS_W-1:0];
                fdmd_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[fdmd_pkg::DIM_W-1:0];
                fdmd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[fdmd_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff    = fdmd_pkg::clamp_dim(r_frame_width, fdmd_pkg::DIM_W'(fdmd_pkg::MAX_WIDTH));
        h_eff    = fdmd_pkg::clamp_dim(r_frame_height, fdmd_pkg::DIM_W'(fdmd_pkg::MAX_HEIGHT));
        total    = fdmd_pkg::TOTAL_W'(w_eff) * fdmd_pkg::TOTAL_W'(h_eff);
        pos_next = fdmd_pkg::TOTAL_W'(r_pos) + fdmd_pkg::TOTAL_W'(1);
        // a shrink mid-frame ends the frame at once
        last     = pos_next >= total;
        accept   = i_valid && !i_q_full;

        n_pos    = r_pos;
        n_primed = r_primed;
        if (accept) begin
            if (last) begin
                n_pos    = '0;
                n_primed = 1'b1;
            end else begin
                n_pos = pos_next[fdmd_pkg::ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_primed <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_primed <= n_primed;
        end
    end

    assign o_push       = accept;
    assign o_job.pixel  = i_pixel;
    assign o_job.addr   = r_pos;
    assign o_job.total  = total;
    assign o_job.last   = last;
    assign o_job.primed = r_primed;

    assign o_cfg_ctl.tolerance   = r_tolerance;
    assign o_cfg_ctl.sensitivity = r_sensitivity;

endmodule

// ----- rtl/fdmd_queue.sv -----
// short job queue between the front and back parts
// depends on fdmd_pkg
module fdmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fdmd_pkg::t_job i_job,
    input  logic           i_pop,
    output fdmd_pkg::t_job o_head,
    output logic           o_not_empty,
    output logic           o_full
);

    fdmd_pkg::t_job                r_slot [fdmd_pkg::Q_DEPTH];
    logic [fdmd_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [fdmd_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [fdmd_pkg::Q_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + fdmd_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + fdmd_pkg::Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + fdmd_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - fdmd_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head      = r_slot[r_rd_ptr];
    assign o_not_empty = r_count != '0;
    assign o_full      = r_count == fdmd_pkg::Q_CNT_W'(fdmd_pkg::Q_DEPTH);

endmodule

// ----- rtl/fdmd_back.sv -----
// back part: pixel store, compare against the stored pixel, count and motion test
// depends on fdmd_pkg
module fdmd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fdmd_pkg::t_job       i_head,
    input  logic                 i_not_empty,
    output logic                 o_pop,
    input  fdmd_pkg::t_cfg_ctl   i_cfg_ctl,
    output logic                 o_valid,
    output fdmd_pkg::t_result    o_result,
    input  logic                 i_stall
);

    fdmd_pkg::t_pixel              r_store [fdmd_pkg::STORE_DEPTH];

    logic                          r_a_valid;
    fdmd_pkg::t_job                r_a_job;
    fdmd_pkg::t_pixel              r_rdata;
    logic                          r_fwd_hit;
    fdmd_pkg::t_pixel              r_fwd_data;
    logic [fdmd_pkg::COUNT_W-1:0]  r_count;
    logic [fdmd_pkg::COUNT_W-1:0]  n_count;
    logic                          r_out_valid;
    fdmd_pkg::t_result             r_out;

    logic                          out_ready;
    logic                          a_move;
    logic                          a_load;
    fdmd_pkg::t_pixel              old_pix;
    logic                          same;
    logic                          changed;
    logic [fdmd_pkg::COUNT_W-1:0]  cnt_new;
    logic [fdmd_pkg::SENS_W-1:0]   sens_eff;
    logic [fdmd_pkg::PROD_W-1:0]   product;
    logic                          motion;

    always_comb begin
        out_ready = !r_out_valid || !i_stall;
        a_move    = r_a_valid && out_ready;
        a_load    = i_not_empty && (!r_a_valid || a_move);

        // the item just ahead may have written this address at the read edge
        old_pix = r_fwd_hit ? r_fwd_data : r_rdata;
        same    = fdmd_pkg::near(r_a_job.pixel.red,   old_pix.red,   i_cfg_ctl.tolerance) &&
                  fdmd_pkg::near(r_a_job.pixel.green, old_pix.green, i_cfg_ctl.tolerance) &&
                  fdmd_pkg::near(r_a_job.pixel.blue,  old_pix.blue,  i_cfg_ctl.tolerance);
        changed = r_a_job.primed && !same;

        cnt_new = r_count;
        if (changed && r_count != fdmd_pkg::COUNT_MAX) begin
            cnt_new = r_count + fdmd_pkg::COUNT_W'(1);
        end

        sens_eff = (i_cfg_ctl.sensitivity == '0) ? fdmd_pkg::SENS_W'(1)
                                                 : i_cfg_ctl.sensitivity;
        // count > floor(total/sens) holds exactly when count*sens > total
        product  = fdmd_pkg::PROD_W'(cnt_new) * fdmd_pkg::PROD_W'(sens_eff);
        motion   = r_a_job.last && r_a_job.primed &&
                   (product > fdmd_pkg::PROD_W'(r_a_job.total));

        n_count = r_count;
        if (a_move) begin
            n_count = r_a_job.last ? '0 : cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_store[r_a_job.addr] <= r_a_job.pixel;
        end
        if (a_load) begin
            r_rdata <= r_store[i_head.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_job    <= i_head;
            r_fwd_hit  <= a_move && (r_a_job.addr == i_head.addr);
            r_fwd_data <= r_a_job.pixel;
        end
        if (a_move) begin
            r_out.changed       <= changed;
            r_out.frame_end     <= r_a_job.last;
            r_out.motion        <= motion;
            r_out.changed_total <= cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (a_load) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    assign o_pop    = a_load;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- rtl/fdmd_checker.sv -----
// port-level checker for the frame difference motion detector
// depends on fdmd_pkg; bound to the top level at the end of this file
module fdmd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input fdmd_pkg::t_pixel                i_pixel,
    input logic                            o_valid,
    input logic                            i_stall,
    input fdmd_pkg::t_result               o_result,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [1:0]                      i_cfg_index,
    input logic [fdmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("output beat changed while stalled");

    a_motion_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.motion |-> o_result.frame_end)
        else $error("motion flagged away from frame end");

    a_changed_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.changed || o_result.motion) |-> o_result.changed_total != '0)
        else $error("changed pixel or motion with zero count");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat right after reset");

endmodule

bind frame_difference_motion_detector_unit fdmd_checker u_fdmd_checker (.*);
